// ----- src/centered_window_mean_smoother_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the centered window mean smoother
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_MEAN_SMOOTHER_MACROS_SVH
`define CENTERED_WINDOW_MEAN_SMOOTHER_MACROS_SVH

// Property that must hold at every clock edge
`define CWMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must be followed by a consequence in the next cycle
`define CWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cwms_pkg.sv -----
// ----------------------------------------------------------------------------
// cwms_pkg
// Shared constants, register indexes and control structs of the smoother.
// ----------------------------------------------------------------------------
package cwms_pkg;

    // Default largest half width of the window
    localparam int MAX_HALF_WIDTH_DEF = 31;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int HW_W       = 5;
    localparam int HW_LIMIT   = 31;
    localparam int PEND_W     = 6;
    localparam int PEND_MAX   = 63;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_PRECIP_MODE = 1'b1
    } t_cfg_idx;

    // Window store controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } t_win_ctl;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- src/centered_window_mean_smoother.sv -----
// ----------------------------------------------------------------------------
// centered_window_mean_smoother
// Centered moving mean over a row of daily samples. Each result is the mean
// of the counted samples within half_width places of its centre inside the
// same row; missing samples, and zero samples in precipitation mode, do not
// count, and an empty window raises no_data with a zero mean. Results lag the
// input by half_width and the rest are flushed on the row's last sample
// (tlast in, tlast out on the final result). The block takes one sample at a
// time and accepts no new sample until each result it releases is loaded
// into the output register: for each result it reads every window position
// through the single read port of the window memory (one memory read per
// cycle), divides the sum serially unless the window is empty, and loads
// the output register once the output is free.
// ----------------------------------------------------------------------------
`include "centered_window_mean_smoother_macros.svh"

module centered_window_mean_smoother #(
    parameter int MAX_HALF_WIDTH = cwms_pkg::MAX_HALF_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cwms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cwms_pkg::DATA_W-1:0]     s_axis_tdata,  // [31:0] sample
    input  logic [0:0]                      s_axis_tuser,  // [0] is_missing
    input  logic                            s_axis_tlast,  // row_end
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cwms_pkg::DATA_W-1:0]     m_axis_tdata,  // [31:0] mean_value
    output logic [0:0]                      m_axis_tuser,  // [0] no_data
    output logic                            m_axis_tlast   // last_of_row
);
    import cwms_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int SLOT_W    = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W     = DATA_W + SLOT_W;
    localparam int EXT_W     = ((CNT_W > PEND_W) ? CNT_W : PEND_W) + 1;
    localparam int HW_CLAMP  = (MAX_HALF_WIDTH < HW_LIMIT) ? MAX_HALF_WIDTH : HW_LIMIT;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SUM   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [HW_W-1:0]     r_half_width;
    logic                r_precip;
    logic [CNT_W-1:0]    r_row_pos;
    logic [PEND_W-1:0]   r_pending;
    logic [SLOT_W-1:0]   r_newest;
    logic                r_row_end;
    logic [SLOT_W-1:0]   r_age;
    logic [SLOT_W-1:0]   r_hi;
    logic                r_iss_done;
    logic                r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_res_mean;
    logic                r_res_nodata;
    logic                r_res_last;
    logic                r_m_valid;
    logic [DATA_W-1:0]   r_m_data;
    logic                r_m_nodata;
    logic                r_m_last;

    logic [HW_W-1:0]     hw;
    logic                in_xfer;
    logic [SLOT_W-1:0]   nxt_slot;
    logic                more;
    logic [EXT_W-1:0]    centre;
    logic [EXT_W-1:0]    lo_ext;
    logic [EXT_W-1:0]    hi_raw;
    logic [EXT_W-1:0]    avail_m1;
    logic [EXT_W-1:0]    hi_ext;
    logic [SLOT_W:0]     age_diff;
    logic [SLOT_W-1:0]   rd_addr;
    logic                rd_issue;
    logic [DATA_W-1:0]   rd_data;
    logic                rd_flag;
    logic                counted;
    logic                sum_end;
    logic                out_free;
    logic                load;
    logic                div_start;
    t_div_sts            div_sts;
    logic [DATA_W-1:0]   div_quot;
    t_win_ctl            win_ctl;

    // Effective half width
    assign hw = (r_half_width > HW_W'(HW_CLAMP)) ? HW_W'(HW_CLAMP) : r_half_width;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Ring slot of the incoming sample; a new row starts at slot zero
    always_comb begin
        if (r_row_pos == '0) begin
            nxt_slot = '0;
        end else if (r_newest == SLOT_W'(WIN_DEPTH - 1)) begin
            nxt_slot = '0;
        end else begin
            nxt_slot = r_newest + 1'b1;
        end
    end

    // Result owed now, and the age span of its window
    assign more     = (r_pending != '0) &&
                      ((EXT_W'(r_pending) > EXT_W'(hw)) || r_row_end);
    assign centre   = EXT_W'(r_pending) - EXT_W'(1);
    assign lo_ext   = (centre > EXT_W'(hw)) ? (centre - EXT_W'(hw)) : '0;
    assign hi_raw   = centre + EXT_W'(hw);
    assign avail_m1 = EXT_W'(r_row_pos) - EXT_W'(1);
    assign hi_ext   = (hi_raw > avail_m1) ? avail_m1 : hi_raw;

    // Slot of a given age, wrapped around the ring
    assign age_diff = {1'b0, r_newest} - {1'b0, r_age};
    assign rd_addr  = age_diff[SLOT_W] ? SLOT_W'(age_diff + (SLOT_W + 1)'(WIN_DEPTH))
                                       : age_diff[SLOT_W-1:0];
    assign rd_issue = (r_state == S_SUM) && !r_iss_done;

    // Sample counts unless missing or a zero in precipitation mode
    assign counted   = rd_flag && !(r_precip && (rd_data == '0));
    assign sum_end   = (r_state == S_SUM) && r_iss_done && !r_rd_vld;
    assign div_start = sum_end && (r_cnt != '0);

    assign out_free = !r_m_valid || m_axis_tready;
    assign load     = (r_state == S_OUT) && out_free;

    assign win_ctl.wr_en = in_xfer;
    assign win_ctl.rd_en = rd_issue;
    assign win_ctl.clr   = (r_state == S_CHECK) && !more && r_row_end;

    cwms_window #(
        .DEPTH  (WIN_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_wr_addr (nxt_slot),
        .i_wr_data (s_axis_tdata),
        .i_wr_flag (!s_axis_tuser[0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_rd_flag (rd_flag)
    );

    cwms_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_cnt),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = more ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (sum_end) n_state = (r_cnt != '0) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_sts.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_CHECK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_half_width <= HW_W'(1);
            r_precip     <= 1'b0;
            r_row_pos    <= '0;
            r_pending    <= '0;
            r_newest     <= '0;
            r_row_end    <= 1'b0;
            r_iss_done   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HALF_WIDTH:  r_half_width <= i_cfg_data[HW_W-1:0];
                    CFG_PRECIP_MODE: r_precip     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // sample transfer
            if (in_xfer) begin
                r_newest  <= nxt_slot;
                r_row_end <= s_axis_tlast;
                if (r_row_pos != CNT_W'(WIN_DEPTH)) r_row_pos <= r_row_pos + 1'b1;
                if (r_pending != PEND_W'(PEND_MAX)) r_pending <= r_pending + 1'b1;
            end

            // row end: forget the row once everything is flushed
            if (win_ctl.clr) begin
                r_row_pos <= '0;
                r_pending <= '0;
            end

            // window read issue
            if (r_state == S_CHECK && more) begin
                r_iss_done <= 1'b0;
            end else if (rd_issue && r_age == r_hi) begin
                r_iss_done <= 1'b1;
            end
            r_rd_vld <= rd_issue;

            // result into the output register
            if (load) begin
                r_m_valid <= 1'b1;
                r_pending <= r_pending - 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK && more) begin
            r_age      <= lo_ext[SLOT_W-1:0];
            r_hi       <= hi_ext[SLOT_W-1:0];
            r_sum      <= '0;
            r_cnt      <= '0;
            r_res_last <= r_row_end && (r_pending == PEND_W'(1));
        end else begin
            if (rd_issue && r_age != r_hi) begin
                r_age <= r_age + 1'b1;
            end
            if (r_rd_vld && counted) begin
                r_sum <= r_sum + {{SLOT_W{rd_data[DATA_W-1]}}, rd_data};
                r_cnt <= r_cnt + 1'b1;
            end
        end

        // empty window or finished quotient
        if (sum_end && r_cnt == '0) begin
            r_res_mean   <= '0;
            r_res_nodata <= 1'b1;
        end else if (div_sts.done) begin
            r_res_mean   <= div_quot;
            r_res_nodata <= 1'b0;
        end

        if (load) begin
            r_m_data   <= r_res_mean;
            r_m_nodata <= r_res_nodata;
            r_m_last   <= r_res_last;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_nodata;
    assign m_axis_tlast    = r_m_last;

    // Checks
    `CWMS_ASSERT(a_pend_bound, r_pending <= PEND_W'(HW_LIMIT + 1), "owed results exceed bound")
    `CWMS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !s_axis_tready, "ready right after transfer")
    `CWMS_ASSERT(a_div_done_state, !div_sts.done || (r_state == S_DIV), "divide done outside wait")
    `CWMS_ASSERT(a_div_start_idle, !(div_start && div_sts.busy), "divider restarted while busy")
    `CWMS_ASSERT_NEXT(a_last_drains, load && r_res_last, r_pending == '0, "row end left owed results")

endmodule

// ----- src/cwms_window.sv -----
// ----------------------------------------------------------------------------
// cwms_window
// Ring store of the latest samples of a row with per-entry valid flags.
// One write and one registered read per cycle; flags clear at row end.
// ----------------------------------------------------------------------------
module cwms_window #(
    parameter int DEPTH  = 63,
    parameter int ADDR_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cwms_pkg::t_win_ctl         i_ctl,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [cwms_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_wr_flag,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [cwms_pkg::DATA_W-1:0] o_rd_data,
    output logic                       o_rd_flag
);
    import cwms_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_flag;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_flag;

    // Sample memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_flag <= r_flag[i_rd_addr];
        end
    end

    // Valid flags: set on write when the sample is present, cleared per row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
        end else if (i_ctl.clr) begin
            r_flag <= '0;
        end else if (i_ctl.wr_en) begin
            r_flag[i_wr_addr] <= i_wr_flag;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_flag = r_rd_flag;

endmodule

// ----- src/cwms_div.sv -----
// ----------------------------------------------------------------------------
// cwms_div
// Serial signed divider: one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module cwms_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]            i_den,
    output cwms_pkg::t_div_sts          o_sts,
    output logic [cwms_pkg::DATA_W-1:0] o_quot
);
    import cwms_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic              r_done;

    logic [NUM_W-1:0]  num_u;
    logic [NUM_W-1:0]  num_mag;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_diff;
    logic              trial_ge;
    logic [NUM_W-1:0]  q_signed;

    // Magnitude of the dividend
    assign num_u   = i_num;
    assign num_mag = num_u[NUM_W-1] ? (~num_u + 1'b1) : num_u;

    // Restoring step
    assign trial      = {r_rem, r_q[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, r_den});
    assign trial_diff = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= num_mag;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NUM_W-1];
                r_step <= STEP_W'(NUM_W);
            end else if (r_step != '0) begin
                r_rem  <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_q    <= {r_q[NUM_W-2:0], trial_ge};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restore the sign and keep the low word
    assign q_signed   = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_quot     = q_signed[DATA_W-1:0];
    assign o_sts.busy = (r_step != '0);
    assign o_sts.done = r_done;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for centered_window_mean_smoother
// Streams rows of daily Q16.16 samples with missing flags and row ends,
// predicts every window mean inside a small scoreboard and checks each output
// transfer field by field. Settings change between phases while the block is
// idle, mid-row too, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import cwms_pkg::*;

    localparam int MAX_HW         = MAX_HALF_WIDTH_DEF;
    localparam int WIN_DEPTH      = 2 * MAX_HW + 1;
    localparam int MAX_PER_SAMPLE = 32;
    localparam int ROW_POS_MAX    = 65535;
    localparam int SETTLE_CYCLES  = 2 * MAX_HW + 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SAMPLES = 124;

    typedef struct {
        logic [DATA_W-1:0] mean_value;
        logic              no_data;
        logic              last_of_row;
    } t_mean_result;

    // Scoreboard: predicts window means per accepted sample, checks results
    class window_mean_scoreboard;
        logic [HW_W-1:0]   half_width;
        logic              precip_mode;
        logic [DATA_W-1:0] sample_ring[WIN_DEPTH];
        bit                sample_counted[WIN_DEPTH];
        int unsigned       row_pos;
        int unsigned       owed;
        int unsigned       newest;
        t_mean_result      expected_means[$];
        int                mismatches;
        int                means_checked;

        function new();
            half_width    = 1;
            precip_mode   = 0;
            row_pos       = 0;
            owed          = 0;
            newest        = 0;
            mismatches    = 0;
            means_checked = 0;
            foreach (sample_counted[i]) sample_counted[i] = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HALF_WIDTH:  half_width  = value[HW_W-1:0];
                CFG_PRECIP_MODE: precip_mode = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_means.size();
        endfunction

        // Note an accepted sample and queue the means it releases
        function void note_sample(logic [DATA_W-1:0] x, bit missing, bit row_end);
            int unsigned  hw, avail, centre, lo, hi, age, slot, cnt;
            longint       sum, quot;
            int           n;
            t_mean_result r;
            hw = half_width;
            if (hw > MAX_HW) hw = MAX_HW;
            newest = (row_pos == 0) ? 0 : (newest + 1) % WIN_DEPTH;
            sample_ring[newest]    = x;
            sample_counted[newest] = !missing;
            if (row_pos < ROW_POS_MAX) row_pos++;
            if (owed < PEND_MAX) owed++;
            avail = (row_pos < WIN_DEPTH) ? row_pos : WIN_DEPTH;
            n = 0;
            // oldest owed centre first; flush everything on row end
            while (n < MAX_PER_SAMPLE && owed > 0 && (owed > hw || row_end)) begin
                centre = owed - 1;
                lo     = (centre > hw) ? centre - hw : 0;
                hi     = centre + hw;
                if (hi >= avail) hi = avail - 1;
                sum = 0;
                cnt = 0;
                for (age = lo; age <= hi; age++) begin
                    slot = (newest + WIN_DEPTH - age) % WIN_DEPTH;
                    if (sample_counted[slot] && !(precip_mode && sample_ring[slot] == 0)) begin
                        sum += longint'($signed(sample_ring[slot]));
                        cnt++;
                    end
                end
                // signed division truncates toward zero
                quot          = (cnt != 0) ? sum / longint'(cnt) : 0;
                r.mean_value  = quot[DATA_W-1:0];
                r.no_data     = (cnt == 0);
                r.last_of_row = row_end && owed == 1;
                expected_means.push_back(r);
                owed--;
                n++;
            end
            if (row_end) begin
                row_pos = 0;
                owed    = 0;
                foreach (sample_counted[i]) sample_counted[i] = 0;
            end
        endfunction

        // Compare one output transfer against the oldest expected mean
        function void check_mean(logic [DATA_W-1:0] mean_value, logic no_data,
                                 logic last_of_row);
            t_mean_result e;
            if (expected_means.size() == 0) begin
                $error("unexpected result: mean_value %h no_data %b last_of_row %b",
                       mean_value, no_data, last_of_row);
                mismatches++;
                return;
            end
            e = expected_means.pop_front();
            means_checked++;
            if (mean_value !== e.mean_value) begin
                $error("mean_value: expected %h, got %h", e.mean_value, mean_value);
                mismatches++;
            end
            if (no_data !== e.no_data) begin
                $error("no_data: expected %b, got %b", e.no_data, no_data);
                mismatches++;
            end
            if (last_of_row !== e.last_of_row) begin
                $error("last_of_row: expected %b, got %b", e.last_of_row, last_of_row);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata   = '0;  // [31:0] sample
    logic [0:0]            s_axis_tuser   = '0;  // [0] is_missing
    logic                  s_axis_tlast   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;         // [31:0] mean_value
    logic [0:0]            m_axis_tuser;         // [0] no_data
    logic                  m_axis_tlast;

    window_mean_scoreboard sb = new();
    bit no_idle      = 0;
    int samples_sent = 0;
    int rows_sent    = 0;
    int settings_run = 0;
    int row_left     = 0;
    int idle_cycles  = 0;

    centered_window_mean_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function int draw_idle();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // Send one sample; returns at the edge where the transfer happens
    task automatic send_sample(logic [DATA_W-1:0] x, bit missing, bit row_end);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= x;
        s_axis_tuser[0] <= missing;
        s_axis_tlast    <= row_end;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_sample(x, missing, row_end);
        samples_sent++;
        if (row_end) rows_sent++;
    endtask

    // Stop sending, wait for every owed mean, then let the block go quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges
    task automatic apply_settings(logic [HW_W-1:0] hw, logic precip);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HALF_WIDTH;
        i_cfg_data <= CFG_DATA_W'(hw);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PRECIP_MODE;
        i_cfg_data <= CFG_DATA_W'(precip);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_register(CFG_HALF_WIDTH, CFG_DATA_W'(hw));
        sb.set_register(CFG_PRECIP_MODE, CFG_DATA_W'(precip));
        settings_run++;
    endtask

    // Result side: random stall per transfer, check on every accepted result
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_mean(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) === 1'b1 ||
            (m_axis_tvalid && m_axis_tready) === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d means owed",
                     WATCHDOG_LIMIT, sb.outstanding());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [DATA_W-1:0] x;
        bit                missing;
        bit                row_end;
        int                phase;
        int                phase_left;
        int                kind;
        logic [HW_W-1:0]   hw;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: half width 1, zeros counted
        settings_run = 1;
        send_sample(32'h7FFF_FFFF, 0, 1);               // one-sample row
        send_sample(32'h7FFF_FFFF, 0, 0);               // extremes of the field
        send_sample(32'h7FFF_FFFF, 0, 0);
        send_sample(32'h8000_0000, 0, 0);
        send_sample(32'h8000_0000, 0, 1);
        send_sample(32'h1234_5678, 1, 0);               // all missing: no data
        send_sample(32'hFFFF_FFFF, 1, 1);
        send_sample(32'hFFFF_FFFD, 0, 0);               // negative means round toward zero
        send_sample(32'h0000_0000, 0, 0);
        send_sample(32'hFFFF_FFFC, 0, 1);
        settle_block();

        // Precipitation mode, no neighbors: zero samples drop out
        apply_settings(0, 1);
        send_sample(32'h0000_0000, 0, 0);
        send_sample(32'h0005_0000, 0, 0);
        send_sample(32'h0000_0000, 1, 0);
        send_sample(32'h0000_0000, 0, 1);
        settle_block();

        // Widest window: short row flushed whole, then a row left open
        apply_settings(31, 0);
        send_sample(32'h0001_0000, 0, 0);
        send_sample(32'hFFFE_0000, 0, 0);
        send_sample(32'h0000_0003, 1, 0);
        send_sample(32'h7FFF_0000, 0, 1);
        for (int i = 0; i < 6; i++) send_sample($urandom, i == 2, 0);
        settle_block();

        // Narrowing mid-row releases the owed centres at once
        apply_settings(2, 0);
        send_sample($urandom, 0, 0);
        send_sample($urandom, 0, 1);
        settle_block();

        // Random phases with fresh settings each time
        phase = 0;
        while (samples_sent < RANDOM_SAMPLES + 26) begin
            case (phase % 3)
                0:       hw = 31;
                1:       hw = 0;
                default: hw = HW_W'($urandom_range(1, 30));
            endcase
            apply_settings(hw, 1'(phase % 2));
            no_idle    = (phase % 4 == 3);
            phase_left = $urandom_range(20, 35);
            while (phase_left > 0) begin
                if (row_left == 0)
                    row_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                           : $urandom_range(1, 12);
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3: x = $urandom;
                    4, 5:       x = '0;
                    6:          x = 32'h7FFF_FFFF;
                    7:          x = 32'h8000_0000;
                    default:    x = DATA_W'($urandom_range(0, 511)) - 32'd256;
                endcase
                missing = ($urandom_range(0, 5) == 0);
                row_end = (row_left == 1);
                send_sample(x, missing, row_end);
                row_left--;
                phase_left--;
            end
            // sender holds off here until every owed mean has come back
            settle_block();
            phase++;
        end
        no_idle = 0;
        settle_block();

        $display("Run covered %0d samples in %0d closed rows under %0d register settings,",
                 samples_sent, rows_sent, settings_run);
        $display("half widths 0 to 31 with mid-row changes, zero exclusion on and off;");
        $display("%0d means checked", sb.means_checked);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
